/* rtl/lat_pkg.sv */
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants for the liveness table with aging.
// ----------------------------------------------------------------------------
package lat_pkg;

  // Width of a life count in an entry.
  localparam int LIFE_W = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_RELAX = 2'd1;
  localparam logic [1:0] REG_LIFE  = 2'd2;

  // Reset values of the configuration registers and the period.
  localparam logic [15:0]       START_RST = 16'd200;
  localparam logic [15:0]       RELAX_RST = 16'd5000;
  localparam logic [LIFE_W-1:0] LIFE_RST  = 4'd3;

  // Lowest period that the block uses, in milliseconds.
  localparam logic [15:0] PERIOD_FLOOR = 16'd100;

  // x / 5 == (x * 0xCCCD) >> 18 for every 16-bit x.
  localparam logic [15:0] DIV5_RECIP = 16'hCCCD;
  localparam int          DIV5_SHIFT = 18;

  // Input opcodes.
  localparam logic OPC_SIGHT = 1'b0;
  localparam logic OPC_TICK  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_LIST = 2'd2;

  // Request from the controller to the period unit.
  typedef struct packed {
    logic update;
    logic changed;
  } period_cmd_t;

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key_out;
    logic        is_new;
    logic        dropped;
    logic        changed;
    logic [4:0]  entry_count;
    logic [15:0] next_period_ms;
    logic        last;
  } result_t;

endpackage

/* rtl/liveness_table_with_aging_top.sv */
// ----------------------------------------------------------------------------
// liveness_table_with_aging_top
// Table of live keys with saturating life counts, aging ticks and an
// adaptive poll period.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A sighting
// (opcode 0) walks the live entries one per cycle through the entry memory's
// single read port and answers with one acknowledge. A tick (opcode 1) walks
// the table once to age and compact it, then, if any insertion or eviction
// happened since the previous tick, walks it again to list every live key
// (one listing per cycle) before the summary; without a change only the
// summary is given. Results appear for exactly one cycle with result_valid
// high; the receiver cannot stall them, so it must take every result as it
// comes. The last result of each input has last set, and busy drops in the
// same cycle that result is shown.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle; a new period setting takes effect
// at the next tick. There is no clearing pass after reset: entries are kept
// packed below the live count, so unwritten memory is never read.
// ----------------------------------------------------------------------------
module liveness_table_with_aging_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [KEY_BITS-1:0] key,
  // Result channel, one strobe per result.
  output logic                result_valid,
  output logic [1:0]          kind,
  output logic [31:0]         key_out,
  output logic                is_new,
  output logic                dropped,
  output logic                changed,
  output logic [4:0]          entry_count,
  output logic [15:0]         next_period_ms,
  output logic                last,
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int LIFE_W = lat_pkg::LIFE_W;
  localparam int ENT_W  = KEY_BITS + LIFE_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_AGE,
    S_LIST
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0]       start_ms;
  logic [15:0]       relax_ms;
  logic [LIFE_W-1:0] life_max;
  logic [LIFE_W-1:0] ceil_life;

  // Table control.
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    wptr;
  logic                pend;
  logic [IDX_W-1:0]    pend_addr;
  logic [KEY_BITS-1:0] key_q;
  logic                insert_seen;
  logic                evict_seen;
  logic                chg_q;

  // Memory ports.
  logic                re;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic [ENT_W-1:0]    rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [LIFE_W-1:0]   rd_life;
  logic [LIFE_W-1:0]   aged_life;
  logic                hit;
  logic                walk_done;

  lat_pkg::period_cmd_t period_cmd;
  logic [15:0]          period_ms;
  lat_pkg::result_t     res;

  assign ceil_life = (life_max == '0) ? LIFE_W'(1) : life_max;

  assign rd_key    = rdata[ENT_W-1:LIFE_W];
  assign rd_life   = rdata[LIFE_W-1:0];
  assign aged_life = (rd_life == '0) ? '0 : rd_life - LIFE_W'(1);
  assign hit       = pend && (rd_key == key_q);

  // Every walk issues one read per cycle while entries remain; the listing
  // walk only runs when the tick saw a change.
  assign re = (idx < cnt) &&
              ((state == S_LOOK) || (state == S_AGE) || (state == S_LIST && chg_q));

  // A walk ends when the last read has been consumed and no more remain.
  assign walk_done = !pend && (idx >= cnt);

  // Write port. Writes land at or below the entry being consumed, or, for an
  // insertion, past the live ones; reads run ahead, so no forwarding is needed.
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    wdata = {rd_key, aged_life};
    unique case (state)
      S_LOOK: begin
        if (hit) begin
          we    = (rd_life < ceil_life);
          waddr = pend_addr;
          wdata = {key_q, rd_life + LIFE_W'(1)};
        end else if (walk_done) begin
          we    = (cnt < DEPTH_C);
          waddr = cnt[IDX_W-1:0];
          wdata = {key_q, ceil_life};
        end
      end
      S_AGE: begin
        if (pend) begin
          we    = (aged_life != '0);
          waddr = wptr[IDX_W-1:0];
          wdata = {rd_key, aged_life};
        end
      end
      default: begin
      end
    endcase
  end

  assign period_cmd.update  = (state == S_AGE) && walk_done;
  assign period_cmd.changed = insert_seen || evict_seen;

  lat_entry_ram #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  lat_period u_period (
    .clk       (clk),
    .rst       (rst),
    .start_ms  (start_ms),
    .relax_ms  (relax_ms),
    .cmd       (period_cmd),
    .period_ms (period_ms)
  );

  // Controller: state, counters, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      idx          <= '0;
      pend         <= 1'b0;
      insert_seen  <= 1'b0;
      evict_seen   <= 1'b0;
      chg_q        <= 1'b0;
      result_valid <= 1'b0;
      start_ms     <= lat_pkg::START_RST;
      relax_ms     <= lat_pkg::RELAX_RST;
      life_max     <= lat_pkg::LIFE_RST;
    end else begin
      result_valid <= 1'b0;
      pend         <= re;
      pend_addr    <= idx[IDX_W-1:0];
      if (re) begin
        idx <= idx + CNT_W'(1);
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          lat_pkg::REG_START: start_ms <= cfg_data;
          lat_pkg::REG_RELAX: relax_ms <= cfg_data;
          lat_pkg::REG_LIFE:  life_max <= cfg_data[LIFE_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_q <= key;
            idx   <= '0;
            wptr  <= '0;
            state <= (opcode == lat_pkg::OPC_TICK) ? S_AGE : S_LOOK;
          end
        end

        S_LOOK: begin
          if (hit) begin
            result_valid <= 1'b1;
            res          <= '{lat_pkg::KIND_ACK, 32'(key_q), 1'b0, 1'b0, 1'b0,
                              5'(cnt), period_ms, 1'b1};
            state        <= S_IDLE;
          end else if (walk_done) begin
            result_valid <= 1'b1;
            if (cnt < DEPTH_C) begin
              cnt         <= cnt + CNT_W'(1);
              insert_seen <= 1'b1;
              res         <= '{lat_pkg::KIND_ACK, 32'(key_q), 1'b1, 1'b0, 1'b0,
                               5'(cnt + CNT_W'(1)), period_ms, 1'b1};
            end else begin
              res         <= '{lat_pkg::KIND_ACK, 32'(key_q), 1'b0, 1'b1, 1'b0,
                               5'(cnt), period_ms, 1'b1};
            end
            state <= S_IDLE;
          end
        end

        S_AGE: begin
          if (pend) begin
            if (aged_life != '0) begin
              wptr <= wptr + CNT_W'(1);
            end else begin
              evict_seen <= 1'b1;
            end
          end else if (walk_done) begin
            // The period unit updates at this same edge.
            cnt         <= wptr;
            chg_q       <= insert_seen || evict_seen;
            insert_seen <= 1'b0;
            evict_seen  <= 1'b0;
            idx         <= '0;
            state       <= S_LIST;
          end
        end

        S_LIST: begin
          if (pend) begin
            result_valid <= 1'b1;
            res          <= '{lat_pkg::KIND_LIST, 32'(rd_key), 1'b0, 1'b0, 1'b1,
                              5'(cnt), period_ms, 1'b0};
          end else if (!chg_q || idx >= cnt) begin
            result_valid <= 1'b1;
            res          <= '{lat_pkg::KIND_SUM, 32'd0, 1'b0, 1'b0, chg_q,
                              5'(cnt), period_ms, 1'b1};
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign kind           = res.kind;
  assign key_out        = res.key_out;
  assign is_new         = res.is_new;
  assign dropped        = res.dropped;
  assign changed        = res.changed;
  assign entry_count    = res.entry_count;
  assign next_period_ms = res.next_period_ms;
  assign last           = res.last;

`ifndef ASSERT_OFF
  // Compaction never writes ahead of the entry being consumed.
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE && pend) |-> (wptr <= CNT_W'(pend_addr)))
    else $error("compaction write pointer passed the read position");

  // The live count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("live count exceeds table depth");

  // Finishing an input always shows its final result in that cycle.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_valid && last))
    else $error("input finished without a final result");

  // An acknowledge is the only result of a sighting.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == lat_pkg::KIND_ACK) |-> last)
    else $error("acknowledge not marked last");

  // A sighting cannot both insert and drop.
  a_new_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_new && dropped))
    else $error("result marked both new and dropped");
`endif

endmodule

/* rtl/lat_entry_ram.sv */
// ----------------------------------------------------------------------------
// lat_entry_ram
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lat_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 36,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lat_period.sv */
// ----------------------------------------------------------------------------
// lat_period
// Poll period unit: derives the effective limits and relax step from the
// configuration and updates the current period once per tick.
// ----------------------------------------------------------------------------
module lat_period (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         start_ms,
  input  logic [15:0]         relax_ms,
  input  lat_pkg::period_cmd_t cmd,
  output logic [15:0]         period_ms
);

  logic [15:0] s_clamp;
  logic [15:0] r_clamp;
  logic [15:0] lo_eff;
  logic [15:0] hi_eff;
  logic [13:0] quarter;
  logic [29:0] prod;
  logic [11:0] step;
  logic [16:0] relaxed;

  // Floor, order and quarter of the span, straight from the configuration
  // registers.
  always_comb begin
    s_clamp = (start_ms < lat_pkg::PERIOD_FLOOR) ? lat_pkg::PERIOD_FLOOR : start_ms;
    r_clamp = (relax_ms < lat_pkg::PERIOD_FLOOR) ? lat_pkg::PERIOD_FLOOR : relax_ms;
    if (s_clamp > r_clamp) begin
      lo_eff  = r_clamp;
      hi_eff  = s_clamp;
      quarter = 14'((s_clamp - r_clamp) >> 2);
    end else begin
      lo_eff  = s_clamp;
      hi_eff  = r_clamp;
      quarter = 14'((r_clamp - s_clamp) >> 2);
    end
  end

  // span / 20 as (span / 4) / 5 by reciprocal multiply. The step is
  // registered once; the user must change the configuration only while idle
  // (the block itself does not enforce this), and a tick accepted after a
  // write reaches its update when the new step is already in place.
  assign prod = 30'(quarter) * 30'(lat_pkg::DIV5_RECIP);

  always_ff @(posedge clk) begin
    step <= 12'(prod >> lat_pkg::DIV5_SHIFT);
  end

  assign relaxed = 17'(period_ms) + 17'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms <= lat_pkg::START_RST;
    end else if (cmd.update) begin
      if (cmd.changed) begin
        period_ms <= lo_eff;
      end else if (relaxed > 17'(hi_eff)) begin
        period_ms <= hi_eff;
      end else begin
        period_ms <= relaxed[15:0];
      end
    end
  end

endmodule

/* tb/tb_liveness_table_with_aging_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_liveness_table_with_aging_top
// Self-checking regression for the liveness table with aging.
// ----------------------------------------------------------------------------
// A queue of poll events (sightings and ticks) is filled phase by phase. A
// clocked driver feeds it to the command port in bursts with random gaps. A
// clocked monitor mirrors every accepted transaction in a table model of its
// own, which queues the reports the block owes. Every report strobe is then
// checked against the oldest owed report. The configuration registers are
// rewritten between phases, only once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_liveness_table_with_aging_top;

  localparam int         TABLE_DEPTH = 16;
  localparam int         KEY_BITS    = 32;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 8;
  localparam int         POOL_SIZE   = 24;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         RELAX_DIV   = 20;

  // One poll event as it is handed to the command port.
  typedef struct packed {
    logic        op;
    logic [31:0] key;
  } poll_event_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode = lat_pkg::OPC_SIGHT;
  logic [KEY_BITS-1:0] key = '0;
  logic                result_valid;
  logic [1:0]          kind;
  logic [31:0]         key_out;
  logic                is_new;
  logic                dropped;
  logic                changed;
  logic [4:0]          entry_count;
  logic [15:0]         next_period_ms;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = lat_pkg::REG_START;
  logic [15:0]         cfg_data = '0;

  liveness_table_with_aging_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .key           (key),
    .result_valid  (result_valid),
    .kind          (kind),
    .key_out       (key_out),
    .is_new        (is_new),
    .dropped       (dropped),
    .changed       (changed),
    .entry_count   (entry_count),
    .next_period_ms(next_period_ms),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table model. It holds its own copy of the configuration registers and of
  // the table, and is advanced once per accepted transaction.
  // --------------------------------------------------------------------------
  logic [15:0] start_ms_reg = lat_pkg::START_RST;
  logic [15:0] relax_ms_reg = lat_pkg::RELAX_RST;
  logic [3:0]  life_max_reg = lat_pkg::LIFE_RST;

  logic [31:0] key_tbl  [TABLE_DEPTH];
  logic [3:0]  life_tbl [TABLE_DEPTH];
  logic [4:0]  live_n     = '0;
  logic [15:0] period_ms  = lat_pkg::START_RST;
  logic        ins_seen   = 1'b0;
  logic        evict_seen = 1'b0;

  // Reports that the block still owes, oldest first.
  lat_pkg::result_t due_reports[$];

  // Stimulus waiting for the driver.
  poll_event_t poll_events[$];

  // Statistics for the closing summary.
  int error_count   = 0;
  int items_taken   = 0;
  int reports_seen  = 0;
  int listings_seen = 0;
  int drops_seen    = 0;
  int inserts_seen  = 0;
  int quiet_ticks   = 0;
  int cfg_writes    = 0;

  function automatic lat_pkg::result_t mk_report(input logic [1:0] kd,
                                                 input logic [31:0] k,
                                                 input logic nw, input logic dr,
                                                 input logic ch, input logic ls);
    lat_pkg::result_t r;
    r.kind           = kd;
    r.key_out        = k;
    r.is_new         = nw;
    r.dropped        = dr;
    r.changed        = ch;
    r.entry_count    = live_n;
    r.next_period_ms = period_ms;
    r.last           = ls;
    return r;
  endfunction

  function automatic void write_model_reg(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      lat_pkg::REG_START: start_ms_reg = val;
      lat_pkg::REG_RELAX: relax_ms_reg = val;
      lat_pkg::REG_LIFE:  life_max_reg = val[3:0];
      default: ;  // The spare index holds no register.
    endcase
  endfunction

  // Advances the table by one poll event and queues the reports it causes.
  function automatic void apply_poll_event(input logic op, input logic [31:0] k);
    int          idx;
    int          w;
    logic [3:0]  ceil_life;
    logic        hit;
    logic        lost;
    logic        chg;
    int unsigned s_ms;
    int unsigned r_ms;
    int unsigned t_ms;
    int unsigned p_ms;
    // A ceiling of zero behaves as one.
    ceil_life = (life_max_reg == 4'd0) ? 4'd1 : life_max_reg;
    if (op == lat_pkg::OPC_SIGHT) begin
      hit  = 1'b0;
      lost = 1'b0;
      for (idx = 0; idx < live_n; idx++) begin
        if (!hit && key_tbl[idx] == k) begin
          // A life above a lowered ceiling is left where it is.
          if (life_tbl[idx] < ceil_life) life_tbl[idx] = life_tbl[idx] + 4'd1;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (live_n < TABLE_DEPTH) begin
          key_tbl[live_n]  = k;
          life_tbl[live_n] = ceil_life;
          live_n           = live_n + 5'd1;
          ins_seen         = 1'b1;
        end else begin
          lost = 1'b1;
        end
      end
      due_reports = {due_reports,
                     mk_report(lat_pkg::KIND_ACK, k, !hit && !lost, lost, 1'b0, 1'b1)};
    end else begin
      // Age every live entry once and close the gaps left by evictions.
      w = 0;
      for (idx = 0; idx < live_n; idx++) begin
        if (life_tbl[idx] != 4'd0) life_tbl[idx] = life_tbl[idx] - 4'd1;
        if (life_tbl[idx] != 4'd0) begin
          key_tbl[w]  = key_tbl[idx];
          life_tbl[w] = life_tbl[idx];
          w++;
        end else begin
          evict_seen = 1'b1;
        end
      end
      for (idx = w; idx < TABLE_DEPTH; idx++) life_tbl[idx] = 4'd0;
      live_n = w[4:0];
      chg    = ins_seen || evict_seen;
      // Effective bounds are floored at 100 ms and put in order.
      s_ms = (start_ms_reg < lat_pkg::PERIOD_FLOOR) ? lat_pkg::PERIOD_FLOOR : start_ms_reg;
      r_ms = (relax_ms_reg < lat_pkg::PERIOD_FLOOR) ? lat_pkg::PERIOD_FLOOR : relax_ms_reg;
      if (s_ms > r_ms) begin
        t_ms = s_ms;
        s_ms = r_ms;
        r_ms = t_ms;
      end
      if (chg) begin
        period_ms = s_ms[15:0];
      end else begin
        p_ms      = period_ms + (r_ms - s_ms) / RELAX_DIV;
        period_ms = (p_ms > r_ms) ? r_ms[15:0] : p_ms[15:0];
      end
      ins_seen   = 1'b0;
      evict_seen = 1'b0;
      if (chg) begin
        for (idx = 0; idx < live_n; idx++) begin
          due_reports = {due_reports,
                         mk_report(lat_pkg::KIND_LIST, key_tbl[idx],
                                   1'b0, 1'b0, 1'b1, 1'b0)};
        end
      end
      due_reports = {due_reports,
                     mk_report(lat_pkg::KIND_SUM, '0, 1'b0, 1'b0, chg, 1'b1)};
    end
  endfunction

  function automatic string describe_report(input lat_pkg::result_t r);
    return $sformatf("kind=%0d key=%h new=%0d drop=%0d chg=%0d cnt=%0d period=%0d last=%0d",
                     r.kind, r.key_out, r.is_new, r.dropped, r.changed,
                     r.entry_count, r.next_period_ms, r.last);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. The command slot is free when nothing is offered or when the
  // offered transaction is taken at this edge. Each launch counts down the
  // current burst; at its end a new burst length and a gap are drawn, and a
  // gap of zero gives long stretches of back-to-back commands.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_commands
    poll_event_t ev;
    if (rst) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (poll_events.size() != 0) begin
        ev = poll_events.pop_front();
        start  <= 1'b1;
        opcode <= ev.op;
        key    <= ev.key;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Reports are checked before the transaction taken at the same
  // edge is predicted, so a stray strobe can never match a fresh entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    lat_pkg::result_t got;
    lat_pkg::result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        write_model_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (result_valid) begin
        got.kind           = kind;
        got.key_out        = key_out;
        got.is_new         = is_new;
        got.dropped        = dropped;
        got.changed        = changed;
        got.entry_count    = entry_count;
        got.next_period_ms = next_period_ms;
        got.last           = last;
        reports_seen++;
        if (kind == lat_pkg::KIND_LIST) listings_seen++;
        if (kind == lat_pkg::KIND_ACK && dropped) drops_seen++;
        if (kind == lat_pkg::KIND_ACK && is_new) inserts_seen++;
        if (kind == lat_pkg::KIND_SUM && !changed) quiet_ticks++;
        if (due_reports.size() == 0) begin
          if (error_count < 10) begin
            $display("[%0t] unexpected report: %s", $realtime, describe_report(got));
          end
          error_count++;
        end else begin
          want = due_reports.pop_front();
          if (got !== want) begin
            if (error_count < 10) begin
              $display("[%0t] report mismatch", $realtime);
              $display("  expected %s", describe_report(want));
              $display("  actual   %s", describe_report(got));
            end
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_poll_event(opcode, key);
        items_taken++;
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("liveness_table_with_aging_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  logic [31:0] key_pool[POOL_SIZE];

  task automatic add_sighting(input logic [31:0] k);
    poll_event_t ev;
    ev.op  = lat_pkg::OPC_SIGHT;
    ev.key = k;
    poll_events = {poll_events, ev};
  endtask

  task automatic add_tick();
    poll_event_t ev;
    ev.op  = lat_pkg::OPC_TICK;
    // The key is ignored on a tick, so random bits there must not matter.
    ev.key = $urandom;
    poll_events = {poll_events, ev};
  endtask

  // Mostly sightings of a pool a little larger than the table, so entries
  // are refreshed, inserted, aged out and dropped; a few stray keys and
  // roughly one tick in four.
  task automatic add_random_traffic(input int count);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) add_sighting(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (pick < 75) add_sighting($urandom);
      else add_tick();
    end
  endtask

  // Waits until every command is taken and every owed report has arrived,
  // then gives the block a few more cycles. Polled on the falling edge so
  // that the clocked blocks have settled.
  task automatic wait_quiet();
    @(negedge clk);
    while (poll_events.size() != 0 || start || busy || due_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase: start, relax, life data, and whether the
  // phase ends with a long run of ticks that empties the table and lets the
  // period relax all the way to its cap.
  logic [15:0] ph_start[6] = '{16'd200, 16'd100,   16'd65535, 16'd50,    16'd300,  16'hFFFF};
  logic [15:0] ph_relax[6] = '{16'd5000, 16'd65535, 16'd100,  16'd0,     16'd9000, 16'hFFFF};
  logic [15:0] ph_life [6] = '{16'd3,    16'd15,    16'd0,    16'hFFF2,  16'd4,    16'd15};
  logic        ph_drain[6] = '{1'b1,     1'b0,      1'b1,     1'b1,      1'b0,     1'b1};

  initial begin : run_phases
    int ph;
    int n;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset settings: both extreme keys, a
    // refresh at the ceiling, a changed tick followed by a quiet one, a
    // refresh below the ceiling, filling the table until a key is dropped,
    // and a tick that ages out two keys and lists the rest.
    add_sighting(32'h0000_0000);
    add_sighting(32'hFFFF_FFFF);
    add_sighting(32'h0000_0000);
    add_sighting(32'h8000_0001);
    add_tick();
    add_tick();
    add_sighting(32'h0000_0000);
    for (n = 0; n < 14; n++) add_sighting(32'h5A00_0000 + n * 32'h0101_0101);
    add_tick();
    wait_quiet();

    for (ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        // The first phase keeps the reset settings.
        write_reg(lat_pkg::REG_START, ph_start[ph]);
        write_reg(lat_pkg::REG_RELAX, ph_relax[ph]);
        write_reg(lat_pkg::REG_LIFE, ph_life[ph]);
        // The spare index must leave every register alone.
        if (ph == 4) write_reg(REG_UNUSED, 16'hFFFF);
        // Refresh part of the pool so new keys keep turning up.
        for (n = 0; n < 4; n++) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
      end
      add_random_traffic(45);
      if (ph_drain[ph]) begin
        for (n = 0; n < 30; n++) add_tick();
      end
      wait_quiet();
    end

    error_count += due_reports.size();
    $display("Covered %0d commands and %0d reports (%0d listings, %0d quiet ticks).",
             items_taken, reports_seen, listings_seen, quiet_ticks);
    $display("Saw %0d insertions, %0d drops on a full table, %0d register writes.",
             inserts_seen, drops_seen, cfg_writes);
    if (error_count == 0) begin
      $display("liveness_table_with_aging_top regression: pass");
    end else begin
      $display("liveness_table_with_aging_top regression: fail");
    end
    $finish;
  end

endmodule
